>>> rtl/led_matrix_row_serializer_core_defines.svh
// Assertion macros for the LED matrix row serializer.
`ifndef LED_MATRIX_ROW_SERIALIZER_CORE_DEFINES_SVH
`define LED_MATRIX_ROW_SERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LMRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LMRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lmrs_pkg.sv
// Shared types and constants for the LED matrix row serializer.
`default_nettype none

package lmrs_pkg;

    localparam int DEF_MATRIX_SIDE     = 8;
    localparam int DEF_COLOUR_BITS     = 8;
    localparam int DEF_CORRECTION_BITS = 144;

    localparam int          WAIT_W           = 16;
    localparam logic [15:0] WAIT_TICKS_RESET = 16'd500;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_REFRESH = 3'd1,
        CMD_SETUP   = 3'd2,
        CMD_LINE    = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_SETUP   = 2'd2,
        MODE_REFRESH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RS_SHIFT    = 2'd0,
        RS_LATCH_HI = 2'd1,
        RS_LATCH_LO = 2'd2,
        RS_FINISH   = 2'd3
    } t_rstep;

    typedef struct packed {
        logic rst;
        logic data;
        logic clk;
        logic latch;
        logic bank;
    } t_pins;

    typedef struct packed {
        logic       reset_n;
        logic       serial_data;
        logic       serial_clock;
        logic       latch_pin;
        logic       bank_select;
        logic [7:0] line_enables;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/lmrs_store.sv
// Frame store: synchronous RAM with per-entry valid bits and write forwarding.
`default_nettype none

module lmrs_store #(
    parameter int MATRIX_SIDE = lmrs_pkg::DEF_MATRIX_SIDE,
    parameter int COLOUR_BITS = lmrs_pkg::DEF_COLOUR_BITS
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_wr_en,
    input  wire logic [$clog2(MATRIX_SIDE*MATRIX_SIDE)-1:0]   i_wr_addr,
    input  wire logic [3*COLOUR_BITS-1:0]                     i_wr_data,
    input  wire logic [$clog2(MATRIX_SIDE*MATRIX_SIDE)-1:0]   i_rd_addr,
    output logic      [3*COLOUR_BITS-1:0]                     o_rd_data
);

    localparam int DEPTH = MATRIX_SIDE * MATRIX_SIDE;
    localparam int DW    = 3 * COLOUR_BITS;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;

    logic [DW-1:0] r_rd_data;
    logic          r_rd_vld;
    logic          r_fwd_hit;
    logic [DW-1:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld  <= r_valid[i_rd_addr];
            // read-during-write returns old data, so carry the new word along
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lmrs_skid.sv
// Result output register with a one-entry skid stage.
`default_nettype none

module lmrs_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire lmrs_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output lmrs_pkg::t_result      o_data,
    input  wire logic              i_stall
);

    logic              r_ov;
    logic              r_sk_v;
    lmrs_pkg::t_result r_out;
    lmrs_pkg::t_result r_skid;
    logic              out_xfer;

    assign out_xfer = r_ov && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (out_xfer) begin
                r_out  <= r_skid;
                r_sk_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_ov || out_xfer) begin
                r_out <= i_data;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= i_data;
                r_sk_v <= 1'b1;
            end
        end else if (out_xfer) begin
            r_ov <= 1'b0;
        end
    end

    assign o_full  = r_sk_v;
    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/led_matrix_row_serializer_core.sv
// Top level of the LED matrix row serializer.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   pixel write, row refresh start, setup start, open line, or tick. Every
//   command produces exactly one result on the output channel
//   (o_out_valid / i_out_stall) giving the driver pin levels, the line
//   enables, busy and a rejected flag after that command.
//   Each tick moves the active pin sequence by one half-phase.
//   Results are presented from a registered output stage, not combinationally.
//   Throughput: one command per cycle while o_in_stall is low; the frame store
//   is read every cycle at the pixel the refresh will need next, so a colour
//   fetch never waits. Receiver stall: results collect in the output
//   register plus one skid entry; o_in_stall rises only when both are full.
//   Reset (i_rst_n low, synchronous): sequencer idle, all pins low, line
//   enables zero, reset wait back to 500 ticks, frame store reads as zero
//   (valid bits cleared together, no clearing pass).
//   i_cfg_we writes the reset wait tick count; write only while idle.
`default_nettype none

`include "led_matrix_row_serializer_core_defines.svh"

module led_matrix_row_serializer_core #(
    parameter int MATRIX_SIDE     = lmrs_pkg::DEF_MATRIX_SIDE,
    parameter int COLOUR_BITS     = lmrs_pkg::DEF_COLOUR_BITS,
    parameter int CORRECTION_BITS = lmrs_pkg::DEF_CORRECTION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [2:0]  i_col,
    input  wire logic [2:0]  i_row,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [3:0]  i_line,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_reset_n,
    output logic             o_serial_data,
    output logic             o_serial_clock,
    output logic             o_latch_pin,
    output logic             o_bank_select,
    output logic [7:0]       o_line_enables,
    output logic             o_busy_res,
    output logic             o_rejected
);

    localparam int AW  = $clog2(MATRIX_SIDE * MATRIX_SIDE);
    localparam int DW  = 3 * COLOUR_BITS;
    localparam int PW  = $clog2(MATRIX_SIDE);
    localparam int BW  = $clog2(COLOUR_BITS);
    localparam int PHW = $clog2(2 * CORRECTION_BITS + 3);

    localparam logic [PW-1:0]  PIXEL_LAST = PW'(MATRIX_SIDE - 1);
    localparam logic [BW-1:0]  BIT_LAST   = BW'(COLOUR_BITS - 1);
    localparam logic [PHW-1:0] PHASE_LAST = PHW'(2 * CORRECTION_BITS + 1);

    // sequencer state
    lmrs_pkg::t_mode  r_mode,   n_mode;
    lmrs_pkg::t_rstep r_rstep,  n_rstep;
    logic [15:0]      r_wait,   n_wait;
    logic [PHW-1:0]   r_phase,  n_phase;
    logic [2:0]       r_line,   n_line;
    logic             r_half,   n_half;
    logic [BW-1:0]    r_bit,    n_bit;
    logic [1:0]       r_colour, n_colour;
    logic [PW-1:0]    r_pixel,  n_pixel;
    logic [COLOUR_BITS-1:0] r_shift, n_shift;
    lmrs_pkg::t_pins  r_pins,   n_pins;
    logic [7:0]       r_lines,  n_lines;
    logic [15:0]      r_wait_ticks;

    logic              in_xfer;
    logic              skid_full;
    logic              busy;
    logic              rejected;
    lmrs_pkg::t_result res;
    lmrs_pkg::t_result out_res;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] cur_entry;
    logic [COLOUR_BITS-1:0] sel_byte;

    assign in_xfer = i_in_valid && !skid_full;
    assign busy    = (r_mode != lmrs_pkg::MODE_IDLE);

    assign wr_addr = AW'(32'(i_col) * MATRIX_SIDE + 32'(i_row));
    assign wr_data = {COLOUR_BITS'(i_red), COLOUR_BITS'(i_green), COLOUR_BITS'(i_blue)};
    // prefetch the pixel the next colour start will use
    assign rd_addr = AW'(32'(n_line) * MATRIX_SIDE + 32'(n_pixel));

    // a line beyond the matrix sends zeros
    assign cur_entry = (32'(r_line) < MATRIX_SIDE) ? rd_data : '0;
    assign sel_byte  = (r_bit == '0) ? cur_entry[32'(r_colour) * COLOUR_BITS +: COLOUR_BITS]
                                     : r_shift;

    lmrs_store #(
        .MATRIX_SIDE (MATRIX_SIDE),
        .COLOUR_BITS (COLOUR_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= lmrs_pkg::MODE_IDLE;
            r_rstep      <= lmrs_pkg::RS_SHIFT;
            r_wait       <= '0;
            r_phase      <= '0;
            r_line       <= '0;
            r_half       <= 1'b0;
            r_bit        <= '0;
            r_colour     <= '0;
            r_pixel      <= '0;
            r_shift      <= '0;
            r_pins       <= '0;
            r_lines      <= '0;
            r_wait_ticks <= lmrs_pkg::WAIT_TICKS_RESET;
        end else begin
            r_mode   <= n_mode;
            r_rstep  <= n_rstep;
            r_wait   <= n_wait;
            r_phase  <= n_phase;
            r_line   <= n_line;
            r_half   <= n_half;
            r_bit    <= n_bit;
            r_colour <= n_colour;
            r_pixel  <= n_pixel;
            r_shift  <= n_shift;
            r_pins   <= n_pins;
            r_lines  <= n_lines;
            if (i_cfg_we) begin
                r_wait_ticks <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_rstep  = r_rstep;
        n_wait   = r_wait;
        n_phase  = r_phase;
        n_line   = r_line;
        n_half   = r_half;
        n_bit    = r_bit;
        n_colour = r_colour;
        n_pixel  = r_pixel;
        n_shift  = r_shift;
        n_pins   = r_pins;
        n_lines  = r_lines;
        rejected = 1'b0;
        wr_en    = 1'b0;

        if (in_xfer) begin
            unique case (i_command)
                lmrs_pkg::CMD_WRITE: begin
                    wr_en = (32'(i_col) < MATRIX_SIDE) && (32'(i_row) < MATRIX_SIDE);
                end
                lmrs_pkg::CMD_REFRESH: begin
                    if (busy) begin
                        rejected = 1'b1;
                    end else begin
                        n_mode   = lmrs_pkg::MODE_REFRESH;
                        n_rstep  = lmrs_pkg::RS_SHIFT;
                        n_line   = i_col;
                        n_half   = 1'b0;
                        n_bit    = '0;
                        n_colour = '0;
                        n_pixel  = '0;
                        n_shift  = '0;
                    end
                end
                lmrs_pkg::CMD_SETUP: begin
                    if (busy) begin
                        rejected = 1'b1;
                    end else begin
                        n_pins  = '0;
                        n_lines = '0;
                        n_mode  = lmrs_pkg::MODE_WAIT;
                        n_wait  = r_wait_ticks;
                        n_phase = '0;
                    end
                end
                lmrs_pkg::CMD_LINE: begin
                    if (!i_line[3]) begin
                        n_lines = r_lines | (8'd1 << i_line[2:0]);
                    end else begin
                        n_lines = '0;
                    end
                end
                lmrs_pkg::CMD_TICK: begin
                    unique case (r_mode)
                        lmrs_pkg::MODE_IDLE: begin
                        end
                        lmrs_pkg::MODE_WAIT: begin
                            if (r_wait != '0) begin
                                n_wait = r_wait - 16'd1;
                            end else begin
                                n_pins      = '0;
                                n_pins.rst  = 1'b1;
                                n_pins.data = 1'b1;
                                n_mode      = lmrs_pkg::MODE_SETUP;
                                n_phase     = PHW'(1);
                            end
                        end
                        lmrs_pkg::MODE_SETUP: begin
                            if (r_phase <= PHASE_LAST) begin
                                n_pins.clk = ~r_phase[0];
                                n_phase    = r_phase + PHW'(1);
                            end else begin
                                n_pins.bank = 1'b1;
                                n_mode      = lmrs_pkg::MODE_IDLE;
                                n_phase     = '0;
                            end
                        end
                        lmrs_pkg::MODE_REFRESH: begin
                            unique case (r_rstep)
                                lmrs_pkg::RS_SHIFT: begin
                                    if (!r_half) begin
                                        n_pins.data = sel_byte[COLOUR_BITS-1];
                                        n_pins.clk  = 1'b0;
                                        n_shift     = sel_byte << 1;
                                        n_half      = 1'b1;
                                    end else begin
                                        n_pins.clk = 1'b1;
                                        n_half     = 1'b0;
                                        if (r_bit == BIT_LAST) begin
                                            n_bit = '0;
                                            if (r_colour == 2'd2) begin
                                                n_colour = '0;
                                                if (r_pixel == PIXEL_LAST) begin
                                                    n_pixel = '0;
                                                    n_rstep = lmrs_pkg::RS_LATCH_HI;
                                                end else begin
                                                    n_pixel = r_pixel + PW'(1);
                                                end
                                            end else begin
                                                n_colour = r_colour + 2'd1;
                                            end
                                        end else begin
                                            n_bit = r_bit + BW'(1);
                                        end
                                    end
                                end
                                lmrs_pkg::RS_LATCH_HI: begin
                                    n_pins.latch = 1'b1;
                                    n_rstep      = lmrs_pkg::RS_LATCH_LO;
                                end
                                lmrs_pkg::RS_LATCH_LO: begin
                                    n_pins.latch = 1'b0;
                                    n_rstep      = lmrs_pkg::RS_FINISH;
                                end
                                lmrs_pkg::RS_FINISH: begin
                                    n_pins.clk = 1'b0;
                                    n_mode     = lmrs_pkg::MODE_IDLE;
                                    n_rstep    = lmrs_pkg::RS_SHIFT;
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res.reset_n      = n_pins.rst;
        res.serial_data  = n_pins.data;
        res.serial_clock = n_pins.clk;
        res.latch_pin    = n_pins.latch;
        res.bank_select  = n_pins.bank;
        res.line_enables = n_lines;
        res.busy_res     = (n_mode != lmrs_pkg::MODE_IDLE);
        res.rejected     = rejected;
    end

    lmrs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .i_stall (i_out_stall)
    );

    assign o_in_stall     = skid_full;
    assign o_reset_n      = out_res.reset_n;
    assign o_serial_data  = out_res.serial_data;
    assign o_serial_clock = out_res.serial_clock;
    assign o_latch_pin    = out_res.latch_pin;
    assign o_bank_select  = out_res.bank_select;
    assign o_line_enables = out_res.line_enables;
    assign o_busy_res     = out_res.busy_res;
    assign o_rejected     = out_res.rejected;

    // bit/colour/pixel counters must be parked whenever no refresh runs
    `LMRS_ASSERT_IMP(a_refresh_parked, r_mode != lmrs_pkg::MODE_REFRESH, (r_half == 1'b0) && (r_bit == '0) && (r_colour == 2'd0) && (r_pixel == '0) && (r_rstep == lmrs_pkg::RS_SHIFT), "refresh counters not parked outside refresh")
    // a start request while busy must leave the sequence untouched
    `LMRS_ASSERT_NXT(a_busy_start_ignored, in_xfer && busy && ((i_command == lmrs_pkg::CMD_REFRESH) || (i_command == lmrs_pkg::CMD_SETUP)), $stable(r_mode) && $stable(r_phase) && $stable(r_line), "start while busy altered the sequence")
    // a tick while idle has no effect on the sequencer
    `LMRS_ASSERT_NXT(a_idle_tick, in_xfer && !busy && (i_command == lmrs_pkg::CMD_TICK), (r_mode == lmrs_pkg::MODE_IDLE) && $stable(r_pins), "tick while idle changed state")
    // the skid entry only fills behind a waiting result
    `LMRS_ASSERT_IMP(a_skid_order, skid_full, o_out_valid, "skid full with empty output register")

endmodule

`default_nettype wire
